>>> src/assert_macros.svh
// assertion macros for the page cache controller
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LPC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LPC_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define LPC_ASSERT(lbl, clk, rstn, prop, msg)
`define LPC_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

>>> src/lpc_pkg.sv
// constants, widths and shared types of the page cache controller
// no dependencies; used by the interfaces, the slot compare unit and the top level
package lpc_pkg;

    localparam int SLOT_COUNT   = 16;
    localparam int PAGE_BYTES   = 256;
    localparam int MEMORY_BYTES = 1048576;

    localparam int ADDR_W  = 32;
    localparam int STAMP_W = 32;
    localparam int PAGE_FW = 12;
    localparam int OFF_FW  = 8;
    localparam int SLOT_FW = 4;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int OFF_W  = $clog2(PAGE_BYTES);

    localparam logic [ADDR_W-1:0] MEM_LIMIT = ADDR_W'(MEMORY_BYTES);
    localparam logic [ADDR_W-1:0] ADDR_FOLD = ADDR_W'(MEMORY_BYTES - 1);
    localparam logic [ADDR_W-1:0] OFF_MASK  = ADDR_W'(PAGE_BYTES - 1);
    localparam logic [SLOT_W-1:0] SLOT_TOP  = SLOT_W'(SLOT_COUNT - 1);

    typedef logic [PAGE_FW-1:0] t_page;
    typedef logic [STAMP_W-1:0] t_stamp;
    typedef logic [SLOT_W-1:0]  t_slot_idx;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef struct packed {
        t_page  page_q;
        t_page  page_key;
        logic   present;
        t_stamp stamp_q;
        logic   vic_set;
        logic   vic_present;
        t_stamp vic_stamp;
    } t_cmp_in;

    typedef struct packed {
        logic hit;
        logic take;
    } t_cmp_res;

endpackage

>>> src/lpc_in_if.sv
// access channel: valid/ready handshake carrying one access item
// depends on lpc_pkg for field widths
interface lpc_in_if;
    logic                       valid;
    logic                       ready;
    logic [lpc_pkg::ADDR_W-1:0]  address;
    logic                       is_write;
    logic [lpc_pkg::STAMP_W-1:0] time_stamp;

    modport source (output valid, address, is_write, time_stamp, input ready);
    modport sink   (input valid, address, is_write, time_stamp, output ready);
endinterface

>>> src/lpc_out_if.sv
// result channel: valid/ready handshake carrying one lookup result item
// depends on lpc_pkg for field widths
interface lpc_out_if;
    logic                       valid;
    logic                       ready;
    logic                       fault;
    logic                       hit;
    logic [lpc_pkg::SLOT_FW-1:0] slot;
    logic [lpc_pkg::OFF_FW-1:0]  page_offset;
    logic                       writeback_valid;
    logic [lpc_pkg::PAGE_FW-1:0] writeback_page;
    logic                       fill_valid;
    logic [lpc_pkg::PAGE_FW-1:0] fill_page;

    modport source (output valid, fault, hit, slot, page_offset, writeback_valid,
                    writeback_page, fill_valid, fill_page, input ready);
    modport sink   (input valid, fault, hit, slot, page_offset, writeback_valid,
                    writeback_page, fill_valid, fill_page, output ready);
endinterface

>>> src/lpc_slot_cmp.sv
// shared slot compare unit: page match and victim preference for one slot
// depends on lpc_pkg for t_cmp_in and t_cmp_res
module lpc_slot_cmp (
    input  lpc_pkg::t_cmp_in  i_cmp,
    output lpc_pkg::t_cmp_res o_res
);

    always_comb begin
        o_res.hit  = i_cmp.present && (i_cmp.page_q == i_cmp.page_key);
        o_res.take = !i_cmp.vic_set || !i_cmp.present
                     || (i_cmp.vic_present && (i_cmp.stamp_q < i_cmp.vic_stamp));
    end

endmodule

>>> src/lru_page_cache_controller.sv
// top level of the fully associative lru page cache map
// depends on lpc_pkg, lpc_in_if, lpc_out_if, lpc_slot_cmp and assert_macros.svh
//
// channel   dir  port    fields
// access    in   i_acc   address, is_write, time_stamp
// result    out  o_res   fault, hit, slot, page_offset, writeback_valid/page,
//                        fill_valid/page
//
// one slot is compared per cycle, highest index first, through one compare unit
// a miss compares every slot; a hit in slot k ends the scan after slot k
// a fault skips the scan and touches no slot
// ready only while idle; a finished item waits in the state until the result
// register is free, and the result register holds through any stall
// synchronous active-low reset clears valid and dirty bits; pages and stamps
// are read only behind a valid bit
module lru_page_cache_controller (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lpc_in_if.sink          i_acc,
    lpc_out_if.source       o_res
);

`include "assert_macros.svh"

    lpc_pkg::t_state    r_state;
    lpc_pkg::t_state    n_state;

    lpc_pkg::t_page     r_page;
    logic [lpc_pkg::OFF_FW-1:0] r_off;
    logic               r_wr;
    lpc_pkg::t_stamp    r_now;
    logic               r_fault;

    lpc_pkg::t_slot_idx r_rd_idx;
    logic               r_rd_more;
    logic               r_cmp_vld;
    lpc_pkg::t_slot_idx r_cmp_idx;

    logic               r_vic_set;
    lpc_pkg::t_slot_idx r_vic_idx;
    logic               r_vic_present;
    logic               r_vic_dirty;
    lpc_pkg::t_page     r_vic_page;
    lpc_pkg::t_stamp    r_vic_stamp;

    logic               r_found;
    lpc_pkg::t_slot_idx r_use_idx;

    logic [lpc_pkg::SLOT_COUNT-1:0] r_present;
    logic [lpc_pkg::SLOT_COUNT-1:0] r_dirty;

    lpc_pkg::t_page     mem_page  [lpc_pkg::SLOT_COUNT];
    lpc_pkg::t_stamp    mem_stamp [lpc_pkg::SLOT_COUNT];
    lpc_pkg::t_page     r_pg_q;
    lpc_pkg::t_stamp    r_st_q;

    logic               r_out_vld;
    logic               r_out_fault;
    logic               r_out_hit;
    logic [lpc_pkg::SLOT_FW-1:0] r_out_slot;
    logic [lpc_pkg::OFF_FW-1:0]  r_out_off;
    logic               r_out_wb_vld;
    lpc_pkg::t_page     r_out_wb_page;
    logic               r_out_fill_vld;
    lpc_pkg::t_page     r_out_fill_page;

    logic                        w_accept;
    logic                        w_fault;
    logic [lpc_pkg::ADDR_W-1:0]  w_masked;
    lpc_pkg::t_page              w_page;
    logic [lpc_pkg::OFF_FW-1:0]  w_off;
    logic                        w_free;
    logic                        w_finish;
    lpc_pkg::t_slot_idx          w_use;
    logic                        w_wb;
    lpc_pkg::t_cmp_in            w_cmp_in;
    lpc_pkg::t_cmp_res           w_cmp;

    assign i_acc.ready = (r_state == lpc_pkg::ST_IDLE);
    assign w_accept    = i_acc.valid && i_acc.ready;
    assign w_fault     = i_acc.address > lpc_pkg::MEM_LIMIT;
    assign w_masked    = i_acc.address & lpc_pkg::ADDR_FOLD;
    assign w_page      = lpc_pkg::PAGE_FW'(w_masked >> lpc_pkg::OFF_W);
    assign w_off       = lpc_pkg::OFF_FW'(w_masked & lpc_pkg::OFF_MASK);

    assign w_free   = !r_out_vld || o_res.ready;
    assign w_finish = (r_state == lpc_pkg::ST_DONE) && w_free;
    assign w_use    = r_found ? r_use_idx : r_vic_idx;
    assign w_wb     = !r_fault && !r_found && r_vic_present && r_vic_dirty;

    always_comb begin
        w_cmp_in.page_q      = r_pg_q;
        w_cmp_in.page_key    = r_page;
        w_cmp_in.present     = r_present[r_cmp_idx];
        w_cmp_in.stamp_q     = r_st_q;
        w_cmp_in.vic_set     = r_vic_set;
        w_cmp_in.vic_present = r_vic_present;
        w_cmp_in.vic_stamp   = r_vic_stamp;
    end

    lpc_slot_cmp u_cmp (
        .i_cmp (w_cmp_in),
        .o_res (w_cmp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            lpc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_fault ? lpc_pkg::ST_DONE : lpc_pkg::ST_SCAN;
                end
            end
            lpc_pkg::ST_SCAN: begin
                if (r_cmp_vld && (w_cmp.hit || (r_cmp_idx == '0))) begin
                    n_state = lpc_pkg::ST_DONE;
                end
            end
            lpc_pkg::ST_DONE: begin
                if (w_free) begin
                    n_state = lpc_pkg::ST_IDLE;
                end
            end
            default: n_state = lpc_pkg::ST_IDLE;
        endcase
    end

    // slot page and stamp store
    always_ff @(posedge i_clk) begin
        if ((r_state == lpc_pkg::ST_SCAN) && r_rd_more) begin
            r_pg_q <= mem_page[r_rd_idx];
            r_st_q <= mem_stamp[r_rd_idx];
        end
        if (w_finish && !r_fault) begin
            if (!r_found) begin
                mem_page[w_use] <= r_page;
            end
            mem_stamp[w_use] <= r_now;
        end
    end

    // item fields, scan datapath and result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page   <= w_page;
            r_off    <= w_off;
            r_wr     <= i_acc.is_write;
            r_now    <= i_acc.time_stamp;
            r_fault  <= w_fault;
            r_rd_idx <= lpc_pkg::SLOT_TOP;
        end else if ((r_state == lpc_pkg::ST_SCAN) && r_rd_more && (r_rd_idx != '0)) begin
            r_rd_idx <= r_rd_idx - 1'b1;
        end
        if (r_state == lpc_pkg::ST_SCAN) begin
            r_cmp_idx <= r_rd_idx;
            if (r_cmp_vld && w_cmp.hit) begin
                r_use_idx <= r_cmp_idx;
            end
            if (r_cmp_vld && !w_cmp.hit && w_cmp.take) begin
                r_vic_idx     <= r_cmp_idx;
                r_vic_present <= r_present[r_cmp_idx];
                r_vic_dirty   <= r_dirty[r_cmp_idx];
                r_vic_page    <= r_pg_q;
                r_vic_stamp   <= r_st_q;
            end
        end
        if (w_finish) begin
            r_out_fault     <= r_fault;
            r_out_hit       <= !r_fault && r_found;
            r_out_slot      <= r_fault ? '0 : lpc_pkg::SLOT_FW'(w_use);
            r_out_off       <= r_fault ? '0 : r_off;
            r_out_wb_vld    <= w_wb;
            r_out_wb_page   <= w_wb ? r_vic_page : '0;
            r_out_fill_vld  <= !r_fault && !r_found;
            r_out_fill_page <= (!r_fault && !r_found) ? r_page : '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lpc_pkg::ST_IDLE;
            r_rd_more <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_vic_set <= 1'b0;
            r_found   <= 1'b0;
            r_present <= '0;
            r_dirty   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_rd_more <= 1'b1;
                r_cmp_vld <= 1'b0;
                r_vic_set <= 1'b0;
                r_found   <= 1'b0;
            end else if (r_state == lpc_pkg::ST_SCAN) begin
                r_cmp_vld <= r_rd_more;
                if (r_rd_idx == '0) begin
                    r_rd_more <= 1'b0;
                end
                if (r_cmp_vld && w_cmp.hit) begin
                    r_found <= 1'b1;
                end
                if (r_cmp_vld && !w_cmp.hit && w_cmp.take) begin
                    r_vic_set <= 1'b1;
                end
            end
            if (w_finish && !r_fault) begin
                r_present[w_use] <= 1'b1;
                r_dirty[w_use]   <= r_found ? (r_dirty[w_use] | r_wr) : r_wr;
            end
            if (w_finish) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.fault           = r_out_fault;
    assign o_res.hit             = r_out_hit;
    assign o_res.slot            = r_out_slot;
    assign o_res.page_offset     = r_out_off;
    assign o_res.writeback_valid = r_out_wb_vld;
    assign o_res.writeback_page  = r_out_wb_page;
    assign o_res.fill_valid      = r_out_fill_vld;
    assign o_res.fill_page       = r_out_fill_page;

    `LPC_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n,
                w_accept |=> (r_state != lpc_pkg::ST_IDLE), "accepted item did not start")
    `LPC_NEVER(a_hit_and_fill, i_clk, i_rst_n,
               r_out_vld && r_out_hit && r_out_fill_vld, "hit with fill request")
    `LPC_NEVER(a_wb_without_fill, i_clk, i_rst_n,
               r_out_vld && r_out_wb_vld && !r_out_fill_vld, "writeback without fill")
    `LPC_ASSERT(a_present_sticky, i_clk, i_rst_n,
                1'b1 |=> (($past(r_present) & ~r_present) == '0), "slot lost its valid bit")

endmodule

>>> tb/tb_lru_page_cache_controller.sv
`timescale 1ns / 1ps
// self-checking bench for the lru page cache map: a directed table, then random accesses
// results are checked against a behavioural slot model; needs lpc_pkg, lpc_in_if, lpc_out_if
module tb_lru_page_cache_controller;

    localparam int RANDOM_ITEMS = 1926;
    localparam int DIRECTED_ROWS = 24;
    localparam int HOLD_OFF_AT = 400;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic                        fault;
        logic                        hit;
        logic [lpc_pkg::SLOT_FW-1:0] slot;
        logic [lpc_pkg::OFF_FW-1:0]  page_offset;
        logic                        writeback_valid;
        lpc_pkg::t_page              writeback_page;
        logic                        fill_valid;
        lpc_pkg::t_page              fill_page;
    } t_lookup;

    typedef struct packed {
        logic [lpc_pkg::ADDR_W-1:0] addr;
        logic                       wr;
        lpc_pkg::t_stamp            stamp;
        logic                       typed;
        t_lookup                    want;
    } t_access_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lpc_in_if  acc_if ();
    lpc_out_if res_if ();

    lru_page_cache_controller DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // slot model
    lpc_pkg::t_page  model_page [lpc_pkg::SLOT_COUNT] = '{default: '0};
    logic            model_present [lpc_pkg::SLOT_COUNT] = '{default: 1'b0};
    logic            model_dirty [lpc_pkg::SLOT_COUNT] = '{default: 1'b0};
    lpc_pkg::t_stamp model_stamp [lpc_pkg::SLOT_COUNT] = '{default: '0};

    t_lookup pending_lookups [$];
    int      mismatches = 0;
    bit      hold_off_req = 1'b0;

    t_access_row directed_steps [DIRECTED_ROWS] = '{
        '{32'h0000_0000, 1'b0, 32'd100, 1'b1,
          '{1'b0, 1'b0, 4'd0, 8'h00, 1'b0, 12'h000, 1'b1, 12'h000}},
        '{32'h000F_FFFF, 1'b1, 32'd200, 1'b1,
          '{1'b0, 1'b0, 4'd1, 8'hFF, 1'b0, 12'h000, 1'b1, 12'hFFF}},
        '{32'h0010_0000, 1'b0, 32'd300, 1'b1,
          '{1'b0, 1'b1, 4'd0, 8'h00, 1'b0, 12'h000, 1'b0, 12'h000}},
        '{32'h0010_0001, 1'b1, 32'd5, 1'b1,
          '{1'b1, 1'b0, 4'd0, 8'h00, 1'b0, 12'h000, 1'b0, 12'h000}},
        '{32'hFFFF_FFFF, 1'b0, 32'd6, 1'b1,
          '{1'b1, 1'b0, 4'd0, 8'h00, 1'b0, 12'h000, 1'b0, 12'h000}},
        '{32'h8000_0000, 1'b1, 32'd7, 1'b1,
          '{1'b1, 1'b0, 4'd0, 8'h00, 1'b0, 12'h000, 1'b0, 12'h000}},
        '{32'h0000_0055, 1'b1, 32'hFFFF_FFFF, 1'b1,
          '{1'b0, 1'b1, 4'd0, 8'h55, 1'b0, 12'h000, 1'b0, 12'h000}},
        '{32'h0001_2301, 1'b0, 32'd1000, 1'b0, '0},
        '{32'h0004_5602, 1'b1, 32'd1001, 1'b0, '0},
        '{32'h0007_8903, 1'b0, 32'd1002, 1'b0, '0},
        '{32'h000A_BC04, 1'b1, 32'd1003, 1'b0, '0},
        '{32'h000D_EF05, 1'b0, 32'd1004, 1'b0, '0},
        '{32'h0008_0006, 1'b1, 32'd1005, 1'b0, '0},
        '{32'h0004_0007, 1'b0, 32'd1006, 1'b0, '0},
        '{32'h0002_0008, 1'b1, 32'd1007, 1'b0, '0},
        '{32'h0001_0009, 1'b0, 32'd1008, 1'b0, '0},
        '{32'h0000_800A, 1'b1, 32'd1009, 1'b0, '0},
        '{32'h0000_400B, 1'b0, 32'd1010, 1'b0, '0},
        '{32'h0000_200C, 1'b1, 32'd1011, 1'b0, '0},
        '{32'h0000_100D, 1'b0, 32'd0, 1'b0, '0},
        '{32'h0000_08AA, 1'b1, 32'd0, 1'b0, '0},
        '{32'h0005_5510, 1'b0, 32'd2000, 1'b0, '0},
        '{32'h000A_AA20, 1'b1, 32'd2001, 1'b0, '0},
        '{32'h0005_55FE, 1'b0, 32'd2002, 1'b0, '0}
    };

    function automatic t_lookup predict_lookup(input logic [lpc_pkg::ADDR_W-1:0] addr,
                                               input logic wr,
                                               input lpc_pkg::t_stamp stamp);
        t_lookup                    res;
        logic [lpc_pkg::ADDR_W-1:0] folded;
        lpc_pkg::t_page             pg;
        int                         found;
        int                         victim;
        int                         used;
        res = '0;
        found = -1;
        victim = -1;
        if (addr > lpc_pkg::MEM_LIMIT) begin
            res.fault = 1'b1;
            return res;
        end
        folded = addr & lpc_pkg::ADDR_FOLD;
        pg = lpc_pkg::t_page'(folded / lpc_pkg::PAGE_BYTES);
        res.page_offset = lpc_pkg::OFF_FW'(folded % lpc_pkg::PAGE_BYTES);
        for (int i = lpc_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
            if (model_present[i] && model_page[i] == pg) begin
                found = i;
                break;
            end
            if (victim < 0 || !model_present[i]
                || (model_present[victim] && model_stamp[i] < model_stamp[victim]))
                victim = i;
        end
        if (found >= 0) begin
            used = found;
            res.hit = 1'b1;
        end else begin
            used = victim;
            if (model_present[used] && model_dirty[used]) begin
                res.writeback_valid = 1'b1;
                res.writeback_page = model_page[used];
            end
            model_page[used] = pg;
            model_present[used] = 1'b1;
            model_dirty[used] = 1'b0;
            res.fill_valid = 1'b1;
            res.fill_page = pg;
        end
        model_stamp[used] = stamp;
        if (wr)
            model_dirty[used] = 1'b1;
        res.slot = lpc_pkg::SLOT_FW'(used);
        return res;
    endfunction

    task automatic offer_access(input logic [lpc_pkg::ADDR_W-1:0] addr, input logic wr,
                                input lpc_pkg::t_stamp stamp, input logic typed,
                                input t_lookup want, input int gap);
        t_lookup predicted;
        repeat (gap) begin
            @(negedge i_clk);
            acc_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        acc_if.valid      <= 1'b1;
        acc_if.address    <= addr;
        acc_if.is_write   <= wr;
        acc_if.time_stamp <= stamp;
        do @(posedge i_clk); while (!acc_if.ready);
        predicted = predict_lookup(addr, wr, stamp);
        pending_lookups.push_back(typed ? want : predicted);
    endtask

    function automatic int pick_gap(input logic calm);
        int pick;
        pick = $urandom_range(99);
        if (calm || pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // stimulus
    initial begin
        lpc_pkg::t_stamp            stamp_now;
        lpc_pkg::t_page             ws_base;
        lpc_pkg::t_page             pg;
        logic [lpc_pkg::ADDR_W-1:0] addr;
        logic                       calm;
        int                         pick;
        int                         gap;
        acc_if.valid      = 1'b0;
        acc_if.address    = '0;
        acc_if.is_write   = 1'b0;
        acc_if.time_stamp = '0;
        stamp_now = 32'd5000;
        ws_base = lpc_pkg::t_page'($urandom);
        calm = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[k])
            offer_access(directed_steps[k].addr, directed_steps[k].wr, directed_steps[k].stamp,
                         directed_steps[k].typed, directed_steps[k].want, $urandom_range(2));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 128 == 0) begin
                calm = ($urandom_range(2) == 0);
                if ($urandom_range(1) == 0)
                    ws_base = lpc_pkg::t_page'($urandom);
            end
            if (n == HOLD_OFF_AT)
                hold_off_req = 1'b1;
            pick = $urandom_range(99);
            if (pick < 6) begin
                addr = $urandom_range(32'hFFFF_FFFF, lpc_pkg::MEMORY_BYTES + 1);
            end else if (pick < 9) begin
                addr = lpc_pkg::ADDR_W'(lpc_pkg::MEMORY_BYTES + $urandom_range(1));
            end else if (pick < 30) begin
                addr = $urandom_range(lpc_pkg::MEMORY_BYTES - 1, 0);
            end else begin
                pg = ws_base + lpc_pkg::t_page'($urandom_range(19));
                addr = lpc_pkg::ADDR_W'(pg) * lpc_pkg::PAGE_BYTES
                       + $urandom_range(lpc_pkg::PAGE_BYTES - 1);
            end
            if ($urandom_range(9) == 0)
                stamp_now = $urandom;
            else
                stamp_now = stamp_now + $urandom_range(3);
            gap = (n >= HOLD_OFF_AT && n < HOLD_OFF_AT + 60) ? 0 : pick_gap(calm);
            offer_access(addr, 1'($urandom_range(1)), stamp_now, 1'b0, '0, gap);
        end
        @(negedge i_clk);
        acc_if.valid <= 1'b0;

        while (pending_lookups.size() != 0)
            @(posedge i_clk);
        repeat (2 * lpc_pkg::SLOT_COUNT + 8) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // result acceptance
    initial begin
        int pick;
        int span;
        res_if.ready = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                repeat (HOLD_OFF_CYCLES) begin
                    @(negedge i_clk);
                    res_if.ready <= 1'b0;
                end
            end
            pick = $urandom_range(99);
            if (pick < 50) begin
                span = $urandom_range(8, 1);
                repeat (span) begin
                    @(negedge i_clk);
                    res_if.ready <= 1'b1;
                end
            end else if (pick < 60) begin
                span = $urandom_range(80, 30);
                repeat (span) begin
                    @(negedge i_clk);
                    res_if.ready <= 1'b1;
                end
            end else begin
                span = (pick < 92) ? $urandom_range(3, 1) : $urandom_range(40, 10);
                repeat (span) begin
                    @(negedge i_clk);
                    res_if.ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_lookup want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_lookups.size() == 0) begin
                $error("result item with no access outstanding");
                mismatches++;
            end else begin
                want = pending_lookups.pop_front();
                check_field("fault", 32'(want.fault), 32'(res_if.fault));
                check_field("hit", 32'(want.hit), 32'(res_if.hit));
                check_field("slot", 32'(want.slot), 32'(res_if.slot));
                check_field("page_offset", 32'(want.page_offset), 32'(res_if.page_offset));
                check_field("writeback_valid", 32'(want.writeback_valid),
                            32'(res_if.writeback_valid));
                check_field("writeback_page", 32'(want.writeback_page),
                            32'(res_if.writeback_page));
                check_field("fill_valid", 32'(want.fill_valid), 32'(res_if.fill_valid));
                check_field("fill_page", 32'(want.fill_page), 32'(res_if.fill_page));
            end
        end
    end

    initial begin
        #(10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
